// ===== rtl/hlpe_pkg.sv =====
package hlpe_pkg;

    localparam int SYMBOLS    = 24;
    localparam int CH_W       = 8;
    localparam int TICK_W     = 15;
    localparam int IDX_W      = 10;
    localparam int LEVEL_W    = 10;
    localparam int POS_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int FIFO_DEPTH = 2;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(SYMBOLS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SATURATION      = 3'd0,
        REG_VALUE_LEVEL     = 3'd1,
        REG_BRIGHTNESS      = 3'd2,
        REG_ONE_HIGH_TICKS  = 3'd3,
        REG_ONE_LOW_TICKS   = 3'd4,
        REG_ZERO_HIGH_TICKS = 3'd5,
        REG_ZERO_LOW_TICKS  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_centi;
        logic [IDX_W-1:0]   led_index;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]  led_number;
        logic [POS_W-1:0]  bit_position;
        logic              bit_level;
        logic [TICK_W-1:0] high_ticks;
        logic [TICK_W-1:0] low_ticks;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [CH_W-1:0] saturation;
        logic [CH_W-1:0] value_level;
        logic [CH_W-1:0] brightness;
    } t_color_cfg;

    typedef struct packed {
        logic [TICK_W-1:0] one_high_ticks;
        logic [TICK_W-1:0] one_low_ticks;
        logic [TICK_W-1:0] zero_high_ticks;
        logic [TICK_W-1:0] zero_low_ticks;
    } t_tick_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  g;
        logic [CH_W-1:0]  r;
        logic [CH_W-1:0]  b;
    } t_pix;

    function automatic logic [CH_W-1:0] f_div255(input logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

endpackage

// ===== rtl/hlpe_front.sv =====
module hlpe_front import hlpe_pkg::*; #(
    parameter int LED_COUNT = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_color_cfg i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in        i_data,
    output logic       o_push,
    input  logic       i_push_ready,
    output t_pix       o_pix
);

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    localparam logic [15:0] RECIP_20 = 16'd52429;

    logic [4:0] r_vld;
    logic       adv;
    logic       in_range;

    logic [14:0]      lvl17;
    logic [30:0]      hq;
    logic [CH_W-1:0]  r1_hue;
    logic [IDX_W-1:0] r1_idx;

    logic [10:0]      h6;
    t_sector          n_sec;
    logic [10:0]      n_rem;
    t_sector          r2_sec;
    logic [CH_W-1:0]  r2_rem;
    logic [IDX_W-1:0] r2_idx;

    logic [CH_W-1:0]  r3_sfq;
    logic [CH_W-1:0]  r3_sft;
    t_sector          r3_sec;
    logic [IDX_W-1:0] r3_idx;

    logic [CH_W-1:0]  r4_p;
    logic [CH_W-1:0]  r4_q;
    logic [CH_W-1:0]  r4_t;
    t_sector          r4_sec;
    logic [IDX_W-1:0] r4_idx;

    logic [CH_W-1:0]  sel_r;
    logic [CH_W-1:0]  sel_g;
    logic [CH_W-1:0]  sel_b;
    t_pix             r5_pix;

    assign adv      = !r_vld[4] || i_push_ready;
    assign o_ready  = adv;
    assign in_range = {1'b0, i_data.led_index} < 11'(LED_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[3:0], i_valid && in_range};
        end
    end

    assign lvl17 = {1'b0, i_data.level_centi, 4'b0} + 15'(i_data.level_centi);
    assign hq    = 31'(lvl17) * 31'(RECIP_20);

    assign h6 = 11'({r1_hue, 2'b0}) + 11'({r1_hue, 1'b0});

    always_comb begin
        if (h6 >= 11'd1530) begin
            n_sec = SEC_0;
            n_rem = '0;
        end else if (h6 >= 11'd1275) begin
            n_sec = SEC_5;
            n_rem = h6 - 11'd1275;
        end else if (h6 >= 11'd1020) begin
            n_sec = SEC_4;
            n_rem = h6 - 11'd1020;
        end else if (h6 >= 11'd765) begin
            n_sec = SEC_3;
            n_rem = h6 - 11'd765;
        end else if (h6 >= 11'd510) begin
            n_sec = SEC_2;
            n_rem = h6 - 11'd510;
        end else if (h6 >= 11'd255) begin
            n_sec = SEC_1;
            n_rem = h6 - 11'd255;
        end else begin
            n_sec = SEC_0;
            n_rem = h6;
        end
    end

    always_comb begin
        case (r4_sec)
            SEC_0: begin
                sel_r = i_cfg.value_level; sel_g = r4_t; sel_b = r4_p;
            end
            SEC_1: begin
                sel_r = r4_q; sel_g = i_cfg.value_level; sel_b = r4_p;
            end
            SEC_2: begin
                sel_r = r4_p; sel_g = i_cfg.value_level; sel_b = r4_t;
            end
            SEC_3: begin
                sel_r = r4_p; sel_g = r4_q; sel_b = i_cfg.value_level;
            end
            SEC_4: begin
                sel_r = r4_t; sel_g = r4_p; sel_b = i_cfg.value_level;
            end
            default: begin
                sel_r = i_cfg.value_level; sel_g = r4_p; sel_b = r4_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_hue <= hq[27:20];
            r1_idx <= i_data.led_index;

            r2_sec <= n_sec;
            r2_rem <= n_rem[CH_W-1:0];
            r2_idx <= r1_idx;

            r3_sfq <= f_div255(16'(i_cfg.saturation) * 16'(r2_rem));
            r3_sft <= f_div255(16'(i_cfg.saturation) * 16'(8'd255 - r2_rem));
            r3_sec <= r2_sec;
            r3_idx <= r2_idx;

            r4_p   <= f_div255(16'(i_cfg.value_level) * 16'(8'd255 - i_cfg.saturation));
            r4_q   <= f_div255(16'(i_cfg.value_level) * 16'(8'd255 - r3_sfq));
            r4_t   <= f_div255(16'(i_cfg.value_level) * 16'(8'd255 - r3_sft));
            r4_sec <= r3_sec;
            r4_idx <= r3_idx;

            r5_pix.idx <= r4_idx;
            r5_pix.g   <= f_div255(16'(sel_g) * 16'(i_cfg.brightness));
            r5_pix.r   <= f_div255(16'(sel_r) * 16'(i_cfg.brightness));
            r5_pix.b   <= f_div255(16'(sel_b) * 16'(i_cfg.brightness));
        end
    end

    assign o_push = r_vld[4];
    assign o_pix  = r5_pix;

endmodule

// ===== rtl/hlpe_fifo.sv =====
module hlpe_fifo import hlpe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_push_ready,
    input  t_pix i_pix,
    output logic o_valid,
    input  logic i_pop,
    output t_pix o_pix
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_pix             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = r_cnt != CNT_W'(FIFO_DEPTH);
    assign o_valid      = r_cnt != '0;
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;
    assign o_pix        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_pix;
        end
    end

endmodule

// ===== rtl/hlpe_back.sv =====
module hlpe_back import hlpe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tick_cfg i_cfg,
    input  logic      i_valid,
    input  t_pix      i_pix,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out      o_data
);

    logic [POS_W-1:0] r_pos;
    logic             r_out_vld;
    t_out             r_out;
    logic             adv;
    logic             emit;
    logic [23:0]      bits;
    logic             bit_now;

    assign adv     = !r_out_vld || i_ready;
    assign emit    = adv && i_valid;
    assign bits    = {i_pix.g, i_pix.r, i_pix.b};
    assign bit_now = bits[POS_W'(LAST_POS - r_pos)];
    assign o_pop   = emit && (r_pos == LAST_POS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= i_valid;
            if (i_valid) begin
                r_pos <= (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.led_number   <= i_pix.idx;
            r_out.bit_position <= r_pos;
            r_out.bit_level    <= bit_now;
            r_out.high_ticks   <= bit_now ? i_cfg.one_high_ticks : i_cfg.zero_high_ticks;
            r_out.low_ticks    <= bit_now ? i_cfg.one_low_ticks : i_cfg.zero_low_ticks;
            r_out.last         <= r_pos == LAST_POS;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// ===== rtl/hue_to_led_pulse_encoder.sv =====
// Converts a level in hundredths into a hue, turns it into RGB with the
// programmed saturation and value, scales each channel by brightness, and
// emits 24 pulse symbols per LED (green, red, blue, MSB first), one symbol
// per cycle when the output is ready and a colour is queued. An item is
// accepted into a five-stage colour pipeline, which feeds a two-entry colour
// queue; the symbol serializer drains that queue, and an index at or beyond
// LED_COUNT yields nothing. When the path is empty, the first symbol passes
// through the five colour stages, the queue and the output register. Up to
// seven colours are held at once: five in the colour pipeline and two in the
// queue, the head of the queue being the colour the serializer is sending.
// The user must write registers through the plain write port only while the
// block is idle; the block itself does not enforce this.
module hue_to_led_pulse_encoder import hlpe_pkg::*; #(
    parameter int LED_COUNT = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data
);

    t_color_cfg r_color;
    t_tick_cfg  r_tick;

    logic fr_push;
    logic fifo_ready;
    t_pix fr_pix;
    logic q_valid;
    logic q_pop;
    t_pix q_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color.saturation     <= 8'd255;
            r_color.value_level    <= 8'd255;
            r_color.brightness     <= 8'd50;
            r_tick.one_high_ticks  <= 15'd8;
            r_tick.one_low_ticks   <= 15'd4;
            r_tick.zero_high_ticks <= 15'd4;
            r_tick.zero_low_ticks  <= 15'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SATURATION:      r_color.saturation     <= i_cfg_data[CH_W-1:0];
                REG_VALUE_LEVEL:     r_color.value_level    <= i_cfg_data[CH_W-1:0];
                REG_BRIGHTNESS:      r_color.brightness     <= i_cfg_data[CH_W-1:0];
                REG_ONE_HIGH_TICKS:  r_tick.one_high_ticks  <= i_cfg_data[TICK_W-1:0];
                REG_ONE_LOW_TICKS:   r_tick.one_low_ticks   <= i_cfg_data[TICK_W-1:0];
                REG_ZERO_HIGH_TICKS: r_tick.zero_high_ticks <= i_cfg_data[TICK_W-1:0];
                REG_ZERO_LOW_TICKS:  r_tick.zero_low_ticks  <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    hlpe_front #(
        .LED_COUNT(LED_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_color),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_data      (i_in_data),
        .o_push      (fr_push),
        .i_push_ready(fifo_ready),
        .o_pix       (fr_pix)
    );

    hlpe_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fr_push),
        .o_push_ready(fifo_ready),
        .i_pix       (fr_pix),
        .o_valid     (q_valid),
        .i_pop       (q_pop),
        .o_pix       (q_pix)
    );

    hlpe_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_tick),
        .i_valid(q_valid),
        .i_pix  (q_pix),
        .o_pop  (q_pop),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_data (o_out_data)
    );

endmodule

// ===== bench/tb_hue_to_led_pulse_encoder.sv =====
module tb_hue_to_led_pulse_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import hlpe_pkg::*;

    localparam int LED_COUNT    = 16;
    localparam int ITEM_TARGET  = 160;
    localparam int PHASE_ITEMS  = 30;
    localparam int SETTLE_CYC   = 16;
    localparam int WATCHDOG_CYC = 2000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out_data;

    hue_to_led_pulse_encoder #(
        .LED_COUNT(LED_COUNT)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [CH_W-1:0]   cfg_sat;
    logic [CH_W-1:0]   cfg_val;
    logic [CH_W-1:0]   cfg_bright;
    logic [TICK_W-1:0] cfg_one_high;
    logic [TICK_W-1:0] cfg_one_low;
    logic [TICK_W-1:0] cfg_zero_high;
    logic [TICK_W-1:0] cfg_zero_low;

    t_in  pixel_q[$];
    t_out symbol_q[$];

    int          sent_items   = 0;
    int          mismatch_cnt = 0;
    int          quiet_cyc    = 0;
    int unsigned in_gap       = 0;
    int unsigned out_wait     = 0;
    int unsigned stall_draw;
    bit          in_quiet     = 1'b0;
    bit          out_quiet    = 1'b0;
    logic        in_fire      = 1'b0;
    logic        out_fire     = 1'b0;

    function automatic int unsigned shade_ch(input int unsigned v, input int unsigned s,
                                             input int unsigned frac);
        return (v * (255 - (s * frac) / 255)) / 255;
    endfunction

    function automatic void encode_pixel(input t_in px);
        int unsigned hue, h6, sector, rem, v, s, p, q, t, r, g, b;
        logic [3*CH_W-1:0] grb;
        logic              bit_val;
        t_out              sym;
        if (32'(px.led_index) >= LED_COUNT) return;
        hue    = ((32'(px.level_centi) * 255) / 300) & 8'hFF;
        h6     = hue * 6;
        sector = h6 / 255;
        rem    = h6 - sector * 255;
        if (sector >= 6) sector = 0;
        v = 32'(cfg_val);
        s = 32'(cfg_sat);
        p = shade_ch(v, s, 255);
        q = shade_ch(v, s, rem);
        t = shade_ch(v, s, 255 - rem);
        case (sector)
            0: begin r = v; g = t; b = p; end
            1: begin r = q; g = v; b = p; end
            2: begin r = p; g = v; b = t; end
            3: begin r = p; g = q; b = v; end
            4: begin r = t; g = p; b = v; end
            default: begin r = v; g = p; b = q; end
        endcase
        grb = {8'((g * 32'(cfg_bright)) / 255), 8'((r * 32'(cfg_bright)) / 255),
               8'((b * 32'(cfg_bright)) / 255)};
        for (int k = 0; k < SYMBOLS; k++) begin
            bit_val          = grb[3*CH_W-1-k];
            sym.led_number   = px.led_index;
            sym.bit_position = POS_W'(k);
            sym.bit_level    = bit_val;
            sym.high_ticks   = bit_val ? cfg_one_high : cfg_zero_high;
            sym.low_ticks    = bit_val ? cfg_one_low : cfg_zero_low;
            sym.last         = (k == SYMBOLS - 1);
            symbol_q.push_back(sym);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // drive the item stream
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (in_gap != 0) begin
                i_in_valid <= 1'b0;
                in_gap     <= in_gap - 1;
            end else if (pixel_q.size() != 0) begin
                i_in_data  <= pixel_q.pop_front();
                i_in_valid <= 1'b1;
                in_gap     <= in_quiet ? 0 : $urandom_range(0, 12);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // throttle the symbol stream
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (out_wait != 0) begin
            i_out_ready <= 1'b0;
            out_wait    <= out_wait - 1;
        end else if (out_fire) begin
            stall_draw = out_quiet ? 0 : $urandom_range(0, 12);
            if (stall_draw != 0) begin
                i_out_ready <= 1'b0;
                out_wait    <= stall_draw - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        in_fire  <= i_in_valid && o_in_ready;
        out_fire <= o_out_valid && i_out_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) encode_pixel(i_in_data);
            if (o_out_valid && i_out_ready) begin
                if (symbol_q.size() == 0) begin
                    $display("%0t: unexpected symbol, expected none, actual led %0d pos %0d",
                             $time, o_out_data.led_number, o_out_data.bit_position);
                    mismatch_cnt++;
                end else begin
                    want = symbol_q.pop_front();
                    check_field("led_number", 32'(want.led_number),
                                32'(o_out_data.led_number));
                    check_field("bit_position", 32'(want.bit_position),
                                32'(o_out_data.bit_position));
                    check_field("bit_level", 32'(want.bit_level), 32'(o_out_data.bit_level));
                    check_field("high_ticks", 32'(want.high_ticks),
                                32'(o_out_data.high_ticks));
                    check_field("low_ticks", 32'(want.low_ticks), 32'(o_out_data.low_ticks));
                    check_field("last", 32'(want.last), 32'(o_out_data.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            quiet_cyc <= 0;
        end else begin
            quiet_cyc <= quiet_cyc + 1;
        end
        if (quiet_cyc >= WATCHDOG_CYC) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cyc);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_SATURATION:      cfg_sat       = data[CH_W-1:0];
            REG_VALUE_LEVEL:     cfg_val       = data[CH_W-1:0];
            REG_BRIGHTNESS:      cfg_bright    = data[CH_W-1:0];
            REG_ONE_HIGH_TICKS:  cfg_one_high  = data[TICK_W-1:0];
            REG_ONE_LOW_TICKS:   cfg_one_low   = data[TICK_W-1:0];
            REG_ZERO_HIGH_TICKS: cfg_zero_high = data[TICK_W-1:0];
            REG_ZERO_LOW_TICKS:  cfg_zero_low  = data[TICK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send(input int unsigned level, input int unsigned idx);
        t_in px;
        px.level_centi = LEVEL_W'(level);
        px.led_index   = IDX_W'(idx);
        sent_items++;
        pixel_q.push_back(px);
    endtask

    // hold until every beat is out and the colour path has emptied
    task automatic wait_idle();
        while (pixel_q.size() != 0 || i_in_valid || symbol_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_val(input int unsigned hi);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return CFG_DATA_W'(hi);
            default: return CFG_DATA_W'($urandom_range(0, hi));
        endcase
    endfunction

    task automatic program_random();
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom_range(0, 127)) << CH_W;
        write_reg(REG_SATURATION, pick_val(255) | junk);
        junk = CFG_DATA_W'($urandom_range(0, 127)) << CH_W;
        write_reg(REG_VALUE_LEVEL, pick_val(255) | junk);
        junk = CFG_DATA_W'($urandom_range(0, 127)) << CH_W;
        write_reg(REG_BRIGHTNESS, pick_val(255) | junk);
        write_reg(REG_ONE_HIGH_TICKS, pick_val(32767));
        write_reg(REG_ONE_LOW_TICKS, pick_val(32767));
        write_reg(REG_ZERO_HIGH_TICKS, pick_val(32767));
        write_reg(REG_ZERO_LOW_TICKS, pick_val(32767));
        if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
    endtask

    initial begin
        int unsigned level, idx;
        cfg_sat       = 8'd255;
        cfg_val       = 8'd255;
        cfg_bright    = 8'd50;
        cfg_one_high  = 15'd8;
        cfg_one_low   = 15'd4;
        cfg_zero_high = 15'd4;
        cfg_zero_low  = 15'd8;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: sector edges, full hue, wrap, out-of-range indexes
        send(0, 0);
        send(300, 15);
        send(299, 1);
        send(301, 2);
        send(1023, 3);
        send(60, 4);
        send(120, 5);
        send(180, 6);
        send(240, 7);
        send(270, 8);
        send(30, 9);
        send(100, LED_COUNT);
        send(500, 1023);
        send(512, 10);
        send(341, 11);
        send(682, 12);
        wait_idle();

        write_reg(REG_SATURATION, 15'h7FFF);
        write_reg(REG_VALUE_LEVEL, 15'd255);
        write_reg(REG_BRIGHTNESS, 15'd255);
        write_reg(REG_ONE_HIGH_TICKS, 15'd32767);
        write_reg(REG_ONE_LOW_TICKS, 15'd0);
        write_reg(REG_ZERO_HIGH_TICKS, 15'd0);
        write_reg(REG_ZERO_LOW_TICKS, 15'd32767);
        write_reg(REG_SPARE, 15'h7FFF);
        in_quiet  = 1'b1;
        out_quiet = 1'b1;
        send(0, 13);
        send(50, 14);
        send(150, 0);
        send(250, 15);
        send(300, 1);
        send(1023, 2);
        wait_idle();

        while (sent_items < ITEM_TARGET) begin
            program_random();
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) begin
                case ($urandom_range(0, 7))
                    0:       level = 300;
                    1:       level = $urandom_range(0, 1) ? 0 : 1023;
                    2:       level = $urandom_range(295, 305);
                    default: level = $urandom_range(0, 1023);
                endcase
                if ($urandom_range(0, 4) == 0) idx = $urandom_range(LED_COUNT, 1023);
                else idx = $urandom_range(0, LED_COUNT - 1);
                send(level, idx);
            end
            wait_idle();
        end

        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
